FILE: src/seeded_bounded_random_draw_unit_defines.svh
`ifndef SEEDED_BOUNDED_RANDOM_DRAW_UNIT_DEFINES_SVH
`define SEEDED_BOUNDED_RANDOM_DRAW_UNIT_DEFINES_SVH

// same-cycle implication
`define SBRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/sbrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbrd_pkg;

  localparam logic [63:0] SM_GAMMA   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2    = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] RESET_SEED = 64'd424242;
  localparam int WARMUP_STEPS = 20;

  typedef logic [3:0][63:0] gen_t;

  typedef struct packed {
    gen_t        s;
    logic [31:0] out;
  } step_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // one xoshiro256++ step; only the low 32 bits of the output are kept
  function automatic step_t gen_step(input gen_t s);
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] n0;
    logic [63:0] n1;
    logic [63:0] n2;
    logic [63:0] n3;
    step_t       r;
    sum = s[0] + s[3];
    t   = s[1] << 17;
    n2  = s[2] ^ s[0];
    n3  = s[3] ^ s[1];
    n1  = s[1] ^ n2;
    n0  = s[0] ^ n3;
    n2  = n2 ^ t;
    n3  = {n3[18:0], n3[63:19]};
    r.s     = {n3, n2, n1, n0};
    r.out   = {sum[8:0], sum[63:41]} + s[0][31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/sbrd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sbrd_mul (
  input  wire logic              clk,
  input  wire sbrd_pkg::mul_req_t req,
  output logic [63:0]            prod
);

  always_ff @(posedge clk) begin
    prod <= {32'd0, req.a} * {32'd0, req.b};
  end

endmodule

`default_nettype wire

FILE: src/seeded_bounded_random_draw_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata / data              | tuser
// in_     | in  | [31:0] bound               | [0] kind (0 draw, 1 reseed)
// out_    | out | [31:0] value               | -
// cfg_    | in  | [63:0] seed_value          | -
//
// Draw: one generator step, multiply and check per word when accepted at once;
// each rejection repeats them; the threshold remainder adds a bit-serial divide,
// remultiply and check. Reseed: 4 splitmix words on the shared 32x32 multiplier,
// then WARMUP_STEPS warm-up steps; the same pass runs after reset with seed 424242.
// in_tready is low during any item; a pending out word does not block reseed.
// cfg is always ready.

module seeded_bounded_random_draw_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] bound
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data
);

  `include "seeded_bounded_random_draw_unit_defines.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SM_ADD = 3'd1;
  localparam logic [2:0] S_SM_MUL = 3'd2;
  localparam logic [2:0] S_WARM   = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_CHK    = 3'd6;
  localparam logic [2:0] S_DIV    = 3'd7;

  localparam int CNT_W = $clog2(32);

  logic [2:0]         state_r, state_nxt;
  logic [63:0]        seed_r, seed_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        z_r, z_nxt;
  logic [63:0]        macc_r, macc_nxt;
  logic [1:0]         mph_r, mph_nxt;
  logic               second_r, second_nxt;
  logic [1:0]         widx_r, widx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  sbrd_pkg::gen_t     gen_r, gen_nxt;
  logic [31:0]        rnd_r, rnd_nxt;
  logic [31:0]        bound_r, bound_nxt;
  logic [31:0]        thresh_r, thresh_nxt;
  logic               thr_ok_r, thr_ok_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        dq_r, dq_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  sbrd_pkg::mul_req_t mreq;
  logic [63:0]        prod;
  sbrd_pkg::step_t    step;
  logic [63:0]        mconst;
  logic [63:0]        sm_sum;
  logic [63:0]        m_res;
  logic [32:0]        div_t;
  logic [31:0]        div_rem;
  logic               in_hs;

  sbrd_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_hs      = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign step    = sbrd_pkg::gen_step(gen_r);
  assign mconst  = second_r ? sbrd_pkg::SM_MUL2 : sbrd_pkg::SM_MUL1;
  assign sm_sum  = acc_r + sbrd_pkg::SM_GAMMA;
  assign m_res   = {macc_r[63:32] + prod[31:0], macc_r[31:0]};
  assign div_t   = {rem_r, dq_r[31]};
  assign div_rem = (div_t >= {1'b0, bound_r}) ? 32'(div_t - {1'b0, bound_r}) : div_t[31:0];

  always_comb begin
    mreq.a = rnd_r;
    mreq.b = bound_r;
    if (state_r == S_SM_MUL) begin
      case (mph_r)
        2'd0: begin
          mreq.a = z_r[31:0];
          mreq.b = mconst[31:0];
        end
        2'd1: begin
          mreq.a = z_r[31:0];
          mreq.b = mconst[63:32];
        end
        2'd2: begin
          mreq.a = z_r[63:32];
          mreq.b = mconst[31:0];
        end
        default: begin
          mreq.a = rnd_r;
          mreq.b = bound_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    acc_nxt       = acc_r;
    z_nxt         = z_r;
    macc_nxt      = macc_r;
    mph_nxt       = mph_r;
    second_nxt    = second_r;
    widx_nxt      = widx_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    rnd_nxt       = rnd_r;
    bound_nxt     = bound_r;
    thresh_nxt    = thresh_r;
    thr_ok_nxt    = thr_ok_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      seed_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_hs) begin
          if (in_tuser) begin
            acc_nxt   = seed_r;
            widx_nxt  = 2'd0;
            state_nxt = S_SM_ADD;
          end else begin
            bound_nxt  = in_tdata;
            thr_ok_nxt = 1'b0;
            state_nxt  = S_STEP;
          end
        end
      end
      S_SM_ADD: begin
        acc_nxt    = sm_sum;
        z_nxt      = sm_sum ^ (sm_sum >> 30);
        mph_nxt    = 2'd0;
        second_nxt = 1'b0;
        state_nxt  = S_SM_MUL;
      end
      S_SM_MUL: begin
        mph_nxt = mph_r + 2'd1;
        case (mph_r)
          2'd1: macc_nxt = prod;
          2'd2: macc_nxt = m_res;
          2'd3: begin
            if (!second_r) begin
              z_nxt      = m_res ^ (m_res >> 27);
              second_nxt = 1'b1;
            end else begin
              gen_nxt[widx_r] = m_res ^ (m_res >> 31);
              widx_nxt        = widx_r + 2'd1;
              if (widx_r == 2'd3) begin
                cnt_nxt   = '0;
                state_nxt = S_WARM;
              end else begin
                state_nxt = S_SM_ADD;
              end
            end
          end
          default: ;
        endcase
      end
      S_WARM: begin
        gen_nxt = step.s;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(sbrd_pkg::WARMUP_STEPS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_STEP: begin
        gen_nxt   = step.s;
        rnd_nxt   = step.out;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!thr_ok_r && (prod[31:0] < bound_r)) begin
          rem_nxt   = '0;
          dq_nxt    = 32'd0 - bound_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (thr_ok_r && (prod[31:0] < thresh_r)) begin
          state_nxt = S_STEP;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = prod[63:32];
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt = div_rem;
        dq_nxt  = dq_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(31)) begin
          thresh_nxt = div_rem;
          thr_ok_nxt = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SM_ADD;
      seed_r      <= sbrd_pkg::RESET_SEED;
      acc_r       <= sbrd_pkg::RESET_SEED;
      widx_r      <= 2'd0;
      mph_r       <= 2'd0;
      second_r    <= 1'b0;
      cnt_r       <= '0;
      thr_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      acc_r       <= acc_nxt;
      widx_r      <= widx_nxt;
      mph_r       <= mph_nxt;
      second_r    <= second_nxt;
      cnt_r       <= cnt_nxt;
      thr_ok_r    <= thr_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    macc_r     <= macc_nxt;
    gen_r      <= gen_nxt;
    rnd_r      <= rnd_nxt;
    bound_r    <= bound_nxt;
    thresh_r   <= thresh_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    out_data_r <= out_data_nxt;
  end

  `SBRD_ASSERT_NEXT(a_draw_starts, clk, rst_n, in_hs && !in_tuser, state_r == S_STEP, "draw did not start with a generator step")
  `SBRD_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == S_DIV, bound_r != 32'd0, "threshold division with zero bound")
  `SBRD_ASSERT_NOW(a_thresh_range, clk, rst_n, state_r == S_CHK && thr_ok_r, thresh_r < bound_r, "threshold not below bound")
  `SBRD_ASSERT_NOW(a_out_from_chk, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_CHK, "result word raised outside check state")

endmodule

`default_nettype wire
